// ===== design/lfdh_pkg.sv =====
// Shared constants and types for the luma frame-difference highlighter.
package lfdh_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int PIX_W   = 8;
    localparam int COORD_W = 11;
    localparam int THR_W   = 8;
    localparam int PHASE_W = 3;
    localparam int SUM_W   = COORD_W + 1;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 8'd10;
    localparam logic [PHASE_W-1:0] PHASE_RESET     = 3'd0;
    localparam logic [PIX_W-1:0]   STRIPE_DARK     = 8'd16;
    localparam logic [PIX_W-1:0]   STRIPE_LIGHT    = 8'd240;
    localparam logic [SUM_W-1:0]   STRIPE_BIT      = 12'h004;

    // Register index, taken from paddr[2].
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_PHASE     = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [PHASE_W-1:0] pattern_phase;
    } cfg_t;

endpackage

// ===== design/lfdh_ram.sv =====
// Generic single-port RAM with registered, read-first output.
module lfdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // The read returns the old contents when the same address is written.
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg <= mem_reg[addr];
            if (we) begin
                mem_reg[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lfdh_cfg.sv =====
// APB register file holding the threshold and the stripe phase.
module lfdh_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lfdh_pkg::cfg_t     cfg
);

    logic [lfdh_pkg::THR_W-1:0]   threshold_reg;
    logic [lfdh_pkg::PHASE_W-1:0] phase_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= lfdh_pkg::THRESHOLD_RESET;
            phase_reg     <= lfdh_pkg::PHASE_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                lfdh_pkg::REG_THRESHOLD: threshold_reg <= pwdata[lfdh_pkg::THR_W-1:0];
                lfdh_pkg::REG_PHASE:     phase_reg     <= pwdata[lfdh_pkg::PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            lfdh_pkg::REG_THRESHOLD: prdata = 32'(threshold_reg);
            lfdh_pkg::REG_PHASE:     prdata = 32'(phase_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.threshold     = threshold_reg;
    assign cfg.pattern_phase = phase_reg;

endmodule

// ===== design/lfdh_pipe.sv =====
// Three-stage pixel pipeline: store access, absolute difference, threshold and select.
module lfdh_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lfdh_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lfdh_pkg::PIX_W-1:0]    s_pix,
    input  logic [lfdh_pkg::COORD_W-1:0]  s_col,
    input  logic [lfdh_pkg::COORD_W-1:0]  s_row,
    input  logic                          s_fend,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lfdh_pkg::PIX_W-1:0]    m_pix,
    output logic                          m_fend
);

    logic accept;
    logic en1, en2, en3;
    logic in_store;
    logic [lfdh_pkg::ADDR_W-1:0] addr;
    logic [lfdh_pkg::SUM_W-1:0]  sum;
    logic [lfdh_pkg::PIX_W-1:0]  old_pix;
    logic [lfdh_pkg::PIX_W-1:0]  diff;

    logic have_prev_reg;

    // Stage 1: sample registered, store read data arrives.
    logic                        v1_reg;
    logic [lfdh_pkg::PIX_W-1:0]  pix1_reg;
    logic                        stripe1_reg;
    logic                        cmp1_reg;
    logic                        fend1_reg;

    // Stage 2: absolute difference.
    logic                        v2_reg;
    logic [lfdh_pkg::PIX_W-1:0]  pix2_reg;
    logic [lfdh_pkg::PIX_W-1:0]  diff2_reg;
    logic                        stripe2_reg;
    logic                        cmp2_reg;
    logic                        fend2_reg;

    // Stage 3: output register.
    logic                        v3_reg;
    logic [lfdh_pkg::PIX_W-1:0]  pix3_reg;
    logic                        fend3_reg;

    // Each stage moves when it is empty or the next one moves, so bubbles close up.
    assign en3     = !v3_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign accept  = s_valid && en1;

    assign in_store = (32'(s_col) < 32'(lfdh_pkg::MAX_WIDTH)) &&
                      (32'(s_row) < 32'(lfdh_pkg::MAX_HEIGHT));
    assign addr = lfdh_pkg::ADDR_W'(s_row) * lfdh_pkg::ADDR_W'(lfdh_pkg::MAX_WIDTH)
                + lfdh_pkg::ADDR_W'(s_col);
    assign sum  = lfdh_pkg::SUM_W'(s_col) + lfdh_pkg::SUM_W'(s_row)
                + lfdh_pkg::SUM_W'(cfg.pattern_phase);

    // Read of the old sample and write of the new one share the same cycle.
    lfdh_ram #(
        .WIDTH (lfdh_pkg::PIX_W),
        .DEPTH (lfdh_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (accept),
        .we    (accept && in_store),
        .addr  (addr),
        .wdata (s_pix),
        .rdata (old_pix)
    );

    assign diff = (pix1_reg > old_pix) ? (pix1_reg - old_pix) : (old_pix - pix1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else if (accept && s_fend) begin
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= accept;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg    <= s_pix;
            stripe1_reg <= |(sum & lfdh_pkg::STRIPE_BIT);
            cmp1_reg    <= in_store && have_prev_reg;
            fend1_reg   <= s_fend;
        end
        if (en2 && v1_reg) begin
            pix2_reg    <= pix1_reg;
            diff2_reg   <= diff;
            stripe2_reg <= stripe1_reg;
            cmp2_reg    <= cmp1_reg;
            fend2_reg   <= fend1_reg;
        end
        if (en3 && v2_reg) begin
            if (cmp2_reg && (diff2_reg > cfg.threshold)) begin
                pix3_reg <= stripe2_reg ? lfdh_pkg::STRIPE_DARK : lfdh_pkg::STRIPE_LIGHT;
            end else begin
                pix3_reg <= pix2_reg;
            end
            fend3_reg <= fend2_reg;
        end
    end

    assign m_valid = v3_reg;
    assign m_pix   = pix3_reg;
    assign m_fend  = fend3_reg;

    // Input is refused only when every stage holds a beat.
    a_ready_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input refused while the pipeline has room");

    // The previous-frame flag is set only by an accepted end-of-frame beat.
    a_prev_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(have_prev_reg) |-> $past(accept && s_fend))
        else $error("previous-frame flag set without a frame end");

    // A beat with no comparison passes its sample through the last stage unchanged.
    a_pass_through: assert property (@(posedge aclk) disable iff (!aresetn)
        (en3 && v2_reg && !cmp2_reg) |=> (m_valid && (m_pix == $past(pix2_reg))))
        else $error("pass-through beat was altered");

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted beat lost at the first stage");

endmodule

// ===== design/luma_frame_diff_highlighter.sv =====
// Top level of the luma frame-difference highlighter.
//
// Usage: one luma sample per beat enters on the s_ channel with its column and
// row in s_tdata and the last sample of each frame marked by s_tlast. Each beat
// yields exactly one beat on the m_ channel: the sample itself, or a stripe
// value of 16 or 240 when it differs from the same position in the previous
// frame by more than the threshold register. The APB port holds the threshold
// (address 0) and the stripe phase (address 4); write them only while idle.
// Beats reach m_tvalid through three registered stages; one is taken per cycle
// while m_tready is high, as the frame store has a single port that returns the
// old sample and stores the new one in the same cycle. Reset clears the pipeline
// and the previous-frame flag, not the store, so the first frame after reset
// passes through unchanged while it fills the store. When the receiver stalls,
// the stages keep filling and s_tready falls only once all of them hold a beat.
module luma_frame_diff_highlighter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_in[7:0], col[18:8], row[29:19], zero[31:30]
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pixel_out[7:0]
    output logic        m_tlast,   // frame_end_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lfdh_pkg::cfg_t cfg;

    lfdh_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfdh_pipe u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_pix   (s_tdata[7:0]),
        .s_col   (s_tdata[18:8]),
        .s_row   (s_tdata[29:19]),
        .s_fend  (s_tlast),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_pix   (m_tdata),
        .m_fend  (m_tlast)
    );

endmodule
